// File: hdl/sfs_pkg.sv
// Shared types, constants and helpers for the serial command frame hunter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sfs_pkg;

  localparam int BYTE_W   = 8;
  localparam int N_OUT    = 4;
  localparam int WRAP_MOD = 255;
  localparam int N_IDS    = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_DEV_TABLE     = 1'b0,
    REG_DEVICE_ENABLE = 1'b1
  } cfg_reg_t;

  // Packed so that dev_addr lands in the lowest bits.
  typedef struct packed {
    byte_t aux_second;
    byte_t aux_first;
    byte_t command;
    byte_t dev_addr;
  } frame_t;

  // Window state seen by the frame checker.
  typedef struct packed {
    logic pending;  // a byte was shifted in and awaits its check
    logic full;     // window holds a whole candidate frame
  } win_stat_t;

  // End-around-carry add of one byte onto a running sum.
  function automatic byte_t wrap_add(input byte_t acc, input byte_t b);
    logic [BYTE_W:0] s;
    s = {1'b0, acc} + {1'b0, b};
    if (s > (BYTE_W+1)'(WRAP_MOD)) begin
      s = s - (BYTE_W+1)'(WRAP_MOD);
    end
    return s[BYTE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/sfs_window.sv
// Byte window shift line, fill count and check-pending flag.
// Depends on sfs_pkg.
`default_nettype none

module sfs_window #(
  parameter int CMD_LEN = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire sfs_pkg::byte_t                        rx_byte,
  input  wire logic                                  flush,
  input  wire logic                                  push,
  input  wire logic                                  out_full,
  output logic [CMD_LEN:0][sfs_pkg::BYTE_W-1:0]      win,
  output sfs_pkg::win_stat_t                         stat
);
  import sfs_pkg::*;

  localparam int WIN_LEN = CMD_LEN + 1;
  localparam int FILL_W  = $clog2(WIN_LEN + 1);

  logic [WIN_LEN-1:0][BYTE_W-1:0] win_r, win_nxt;
  logic [FILL_W-1:0]              fill_r, fill_nxt;
  logic                           pend_r, pend_nxt;
  logic                           accept;
  logic [FILL_W-1:0]              fill_base;

  assign in_ready = !(pend_r && out_full);
  assign accept   = in_valid && in_ready;

  always_comb begin
    win_nxt   = win_r;
    fill_base = push ? '0 : fill_r;
    fill_nxt  = fill_base;
    pend_nxt  = (pend_r && out_full);
    if (accept) begin
      pend_nxt = !flush;
      if (flush) begin
        fill_nxt = '0;
      end else begin
        // oldest byte sits at index 0; advance the line by one byte
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[WIN_LEN-1] = rx_byte;
        if (fill_base != FILL_W'(WIN_LEN)) begin
          fill_nxt = fill_base + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign win  = win_r;
  // pending is the upper bit of the status word
  assign stat = {pend_r, (fill_r == FILL_W'(WIN_LEN))};

endmodule

`default_nettype wire

// File: hdl/sfs_check.sv
// Frame check on the current window: identifier match and checksum compare.
// Depends on sfs_pkg.
`default_nettype none

module sfs_check #(
  parameter int CMD_LEN     = 4,
  parameter int MAX_DEVICES = 8
) (
  input  wire logic [CMD_LEN:0][sfs_pkg::BYTE_W-1:0]   win,
  input  wire sfs_pkg::win_stat_t                      stat,
  input  wire logic [sfs_pkg::N_IDS*sfs_pkg::BYTE_W-1:0] dev_table,
  input  wire logic [sfs_pkg::N_IDS-1:0]               device_enable,
  output logic                                         frame_ok,
  output sfs_pkg::frame_t                              frame
);
  import sfs_pkg::*;

  logic  id_hit;
  byte_t sum;
  logic [N_OUT-1:0][BYTE_W-1:0] fields;

  always_comb begin
    id_hit = 1'b0;
    for (int k = 0; k < MAX_DEVICES; k++) begin
      if (device_enable[k] && (dev_table[BYTE_W*k +: BYTE_W] == win[0])) begin
        id_hit = 1'b1;
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < CMD_LEN; i++) begin
      sum = wrap_add(sum, win[i]);
    end
  end

  // bytes past the frame length read as zero
  always_comb begin
    for (int j = 0; j < N_OUT; j++) begin
      fields[j] = (j < CMD_LEN) ? win[j] : '0;
    end
  end

  assign frame_ok = stat.pending && stat.full && id_hit && (sum == win[CMD_LEN]);
  assign frame    = frame_t'(fields);

endmodule

`default_nettype wire

// File: hdl/sfs_skid.sv
// Output register with a skid entry for the result channel.
// Depends on sfs_pkg.
`default_nettype none

module sfs_skid (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sfs_pkg::frame_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sfs_pkg::frame_t      out_data
);
  import sfs_pkg::*;

  logic   main_v_r, main_v_nxt;
  logic   skid_v_r, skid_v_nxt;
  frame_t main_d_r, main_d_nxt;
  frame_t skid_d_r, skid_d_nxt;
  logic   pop;

  assign pop = main_v_r && out_ready;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (pop) begin
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_v_nxt = 1'b1;
        main_d_nxt = push_data;
      end else begin
        // receiver stalled: park the transaction
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_data;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

endmodule

`default_nettype wire

// File: hdl/sio_command_frame_sync.sv
// Serial command frame hunter: top level with configuration registers.
// Depends on sfs_pkg, sfs_window, sfs_check and sfs_skid.
//
// Usage:
//   in_*  : one received byte per transaction; in_tdata = rx_byte, in_tuser = flush.
//           A flush transaction empties the window and its byte is dropped.
//   out_* : one transaction per detected frame. out_tdata carries dev_addr,
//           command, aux_first and aux_second, lowest bits first.
//   cfg_* : register writes, always ready. Index 0 = identifier table (64 bits),
//           index 1 = device_enable (low 8 bits of cfg_data).
// Timing: a byte is shifted into the window at its accept edge and checked in
//   the following cycle; a passing check is registered into the output
//   register or, while the receiver stalls, into the skid entry. One
//   byte per cycle is sustained while in_tready stays high; the window shift
//   line and a combinational check set that rate.
// Stalls: the result path has an output register plus one skid entry. in_tready
//   drops only while a checked byte waits and the skid entry is occupied.
// Reset: rst_n (synchronous) empties the window, clears pending results and
//   zeroes both configuration registers.
`default_nettype none

module sio_command_frame_sync #(
  parameter int CMD_LEN     = 4,
  parameter int MAX_DEVICES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] flush
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] dev_addr, [15:8] command,
                                       // [23:16] aux_first, [31:24] aux_second
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);
  import sfs_pkg::*;

  logic [N_IDS*BYTE_W-1:0]        dev_table_r;
  logic [N_IDS-1:0]               device_enable_r;
  logic [CMD_LEN:0][BYTE_W-1:0]   win;
  win_stat_t                      win_stat;
  logic                           frame_ok;
  frame_t                         frame;
  frame_t                         out_frame;
  logic                           out_full;
  logic                           push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_table_r     <= '0;
      device_enable_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEV_TABLE:     dev_table_r     <= cfg_data;
        REG_DEVICE_ENABLE: device_enable_r <= cfg_data[N_IDS-1:0];
        default: ;
      endcase
    end
  end

  sfs_window #(
    .CMD_LEN (CMD_LEN)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .rx_byte  (in_tdata),
    .flush    (in_tuser[0]),
    .push     (push),
    .out_full (out_full),
    .win      (win),
    .stat     (win_stat)
  );

  sfs_check #(
    .CMD_LEN     (CMD_LEN),
    .MAX_DEVICES (MAX_DEVICES)
  ) u_check (
    .win           (win),
    .stat          (win_stat),
    .dev_table     (dev_table_r),
    .device_enable (device_enable_r),
    .frame_ok      (frame_ok),
    .frame         (frame)
  );

  // hold the check while the skid entry is occupied
  assign push = frame_ok && !out_full;

  sfs_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (frame),
    .full      (out_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_frame)
  );

  assign out_tdata = out_frame;

  a_push_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (win_stat.full && win_stat.pending))
    else $error("frame emitted from a window that is not full");

  a_push_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !win_stat.full)
    else $error("window not emptied after a frame");

  a_stall_only_when_backed_up: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && out_full && win_stat.pending))
    else $error("input stalled without a backed-up result path");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sio_command_frame_sync: streams bytes and flushes,
// rewrites the device table between phases and checks every detected frame.
// Depends on sfs_pkg and the RTL of the block.

module tb;
  import sfs_pkg::*;

  localparam int CMD_LEN     = 4;
  localparam int WIN_LEN     = CMD_LEN + 1;
  localparam int MAX_REPORTS = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = REG_DEV_TABLE;
  logic [63:0] cfg_data   = '0;

  // Predictor state: device table, receive window and frames still owed.
  logic [63:0] ids_reg    = '0;
  logic [7:0]  enable_reg = '0;
  byte_t       win_bytes[WIN_LEN];
  int          win_fill   = 0;
  frame_t      frames_due[$];

  int err_count      = 0;
  int bytes_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  sio_command_frame_sync u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic byte_t eac_add(input byte_t acc, input byte_t b);
    int s;
    s = int'(acc) + int'(b);
    if (s > 255) begin
      s = s - 255;
    end
    return byte_t'(s);
  endfunction

  function automatic bit id_enabled(input byte_t b);
    for (int k = 0; k < N_IDS; k++) begin
      if (enable_reg[k] && ids_reg[8*k +: 8] == b) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // Advance the window by one accepted transaction and queue any frame it closes.
  function automatic void track_byte(input byte_t b, input bit flush);
    byte_t  sum;
    frame_t f;
    if (flush) begin
      win_fill = 0;
      return;
    end
    if (win_fill < WIN_LEN) begin
      win_bytes[win_fill] = b;
      win_fill++;
    end else begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_bytes[i] = win_bytes[i+1];
      end
      win_bytes[WIN_LEN-1] = b;
    end
    if (win_fill < WIN_LEN || !id_enabled(win_bytes[0])) begin
      return;
    end
    sum = '0;
    for (int i = 0; i < CMD_LEN; i++) begin
      sum = eac_add(sum, win_bytes[i]);
    end
    if (sum != win_bytes[CMD_LEN]) begin
      return;
    end
    f.dev_addr   = win_bytes[0];
    f.command    = win_bytes[1];
    f.aux_first  = win_bytes[2];
    f.aux_second = win_bytes[3];
    frames_due.push_back(f);
    win_fill = 0;
  endfunction

  function automatic byte_t pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  function automatic byte_t pick_id();
    byte_t pool[$];
    for (int k = 0; k < N_IDS; k++) begin
      if (enable_reg[k]) begin
        pool.push_back(ids_reg[8*k +: 8]);
      end
    end
    if (pool.size() == 0) begin
      return pick_byte();
    end
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  // Compare each frame against the oldest one owed; set the next stall.
  always @(posedge clk) begin : check_frames
    frame_t got;
    frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (frames_due.size() == 0) begin
        note_error($sformatf("unexpected frame %h", out_tdata));
      end else begin
        want = frames_due.pop_front();
        if (got.dev_addr != want.dev_addr || got.command != want.command ||
            got.aux_first != want.aux_first || got.aux_second != want.aux_second) begin
          note_error($sformatf(
            "frame mismatch: expected dev %h cmd %h aux %h %h, got dev %h cmd %h aux %h %h",
            want.dev_addr, want.command, want.aux_first, want.aux_second,
            got.dev_addr, got.command, got.aux_first, got.aux_second));
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_traffic(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_byte(input byte_t b, input bit flush);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= flush;
    do @(posedge clk); while (!in_tready);
    track_byte(b, flush);
    if (!flush) begin
      bytes_sent++;
    end
  endtask

  task automatic send_five(input byte_t b0, input byte_t b1, input byte_t b2,
                           input byte_t b3, input byte_t b4);
    send_byte(b0, 1'b0);
    send_byte(b1, 1'b0);
    send_byte(b2, 1'b0);
    send_byte(b3, 1'b0);
    send_byte(b4, 1'b0);
  endtask

  // Build a frame around the given identifier; corrupt the checksum when asked.
  task automatic send_frame(input byte_t id, input bit good);
    byte_t body[CMD_LEN];
    byte_t sum;
    body[0] = id;
    for (int i = 1; i < CMD_LEN; i++) begin
      body[i] = pick_byte();
    end
    sum = '0;
    for (int i = 0; i < CMD_LEN; i++) begin
      sum = eac_add(sum, body[i]);
      send_byte(body[i], 1'b0);
    end
    if (!good) begin
      sum = sum ^ byte_t'($urandom_range(1, 255));
    end
    send_byte(sum, 1'b0);
  endtask

  // Hold the input until every owed frame is out and the checker has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic load_devices(input logic [63:0] ids, input logic [7:0] en);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEV_TABLE;
    cfg_data  <= ids;
    do @(posedge clk); while (!cfg_ready);
    ids_reg = ids;
    cfg_index <= REG_DEVICE_ENABLE;
    cfg_data  <= {56'b0, en};
    do @(posedge clk); while (!cfg_ready);
    enable_reg = en;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames, plus bad checksums, foreign ids, noise and flushes.
  task automatic run_stream(input int n_bytes);
    int target;
    int r;
    int n_noise;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      r = $urandom_range(99);
      if (r < 60) begin
        send_frame(pick_id(), 1'b1);
      end else if (r < 72) begin
        send_frame(pick_id(), 1'b0);
      end else if (r < 80) begin
        send_frame(pick_byte(), 1'b1);
      end else if (r < 90) begin
        n_noise = $urandom_range(1, 4);
        repeat (n_noise) send_byte(pick_byte(), 1'b0);
      end else if (r < 96) begin
        n_noise = $urandom_range(1, 4);
        repeat (n_noise) send_byte(pick_byte(), 1'b0);
        send_byte(pick_byte(), 1'b1);
      end else begin
        send_byte(pick_byte(), 1'b1);
      end
    end
  endtask

  // Reset leaves every identifier disabled: a clean zero frame must stay silent.
  task automatic test_disabled_after_reset();
    send_five(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_byte_extremes();
    send_five(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_five(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_flush();
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_five(8'h00, 8'h7F, 8'h80, 8'h00, 8'hFF);
  endtask

  // Bad checksum, then a foreign byte, then a frame reached by sliding.
  task automatic test_checksum_and_slide();
    send_five(8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFF);
    send_byte(8'h11, 1'b0);
    send_five(8'hFF, 8'h01, 8'h00, 8'h00, 8'h01);
  endtask

  task automatic test_random_stream();
    byte_t dup_id;
    load_devices({$urandom, $urandom}, 8'hFF);
    run_stream(320);
    load_devices(64'h0, 8'h80);
    run_stream(160);
    settle();
    run_stream(160);
    set_traffic(71, 26);
    load_devices({64{1'b1}}, 8'h01);
    run_stream(320);
    dup_id = byte_t'($urandom_range(255));
    load_devices({8{dup_id}}, 8'($urandom_range(1, 255)));
    run_stream(320);
    set_traffic(0, 0);
    load_devices({$urandom, $urandom}, 8'h00);
    run_stream(120);
    load_devices({$urandom, $urandom}, 8'hFF);
    run_stream(320);
  endtask

  initial begin
    set_traffic(26, 71);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled_after_reset();
    // FF sits in entries 0 and 7, 00 in entry 6; entry 1 (11) stays off.
    load_devices(64'hFF00_5544_3322_11FF, 8'hC1);
    test_byte_extremes();
    test_flush();
    test_checksum_and_slide();
    test_random_stream();
    settle();
    repeat (10) @(posedge clk);
    if (err_count == 0 && frames_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
hdl/sfs_pkg.sv
hdl/sfs_window.sv
hdl/sfs_check.sv
hdl/sfs_skid.sv
hdl/sio_command_frame_sync.sv
tb/tb.sv
